### rtl/cmae_pkg.sv
// Shared types and constants for the circular mean angle estimator.
// Holds the CORDIC arctangent table and the fixed-point widths; no dependencies.
package cmae_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    // 2^42 * 1.65 * sqrt(2) fits in 44 bits, plus headroom for the sign
    localparam int XY_W         = 46;
    localparam int Z_W          = 34;
    localparam int Q15_W        = 16;
    localparam int SUM_W        = 27;
    localparam int ANGLE_W      = 16;

    localparam longint SUM_CAP  = 64'sd67108863;

    typedef logic signed [XY_W-1:0]  xy_t;
    typedef logic signed [Z_W-1:0]   z_t;
    typedef logic signed [Q15_W-1:0] q15_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // 0.607252935 * 2^30, gain-compensated start value
    localparam xy_t  X_INIT    = 46'sd652032874;
    localparam z_t   HALF_TURN = 34'sd2147483648;
    localparam q15_t Q15_MAX   = 16'sd32767;
    localparam q15_t Q15_MIN   = -16'sd32768;

    // atan(2^-i) as a fraction of a turn, 2^32 = one turn
    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933405, 30'd167458907, 30'd85004756,
        30'd42667332,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335081,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861
    };

endpackage

### rtl/circular_mean_angle_estimator.sv
// Circular mean angle estimator: sums sine/cosine of good samples, atan2 on last.
// One shared CORDIC step unit serves both rotation and vectoring; uses cmae_pkg.
//
//  channel  | dir | tdata               | tuser          | tlast
//  ---------+-----+---------------------+----------------+-------------
//  s_*      | in  | [15:0] sample_angle | [0] sample_ok  | last_sample
//  m_*      | out | [15:0] mean_angle   | [0] found      | -
//
// A skipped, non-final request goes straight back to idle; a good non-final one
// runs 16 rotation steps, a rounding state and an accumulate state. A final
// request adds a check state, 16 vectoring steps (none when both sums are zero)
// and an output state. The single CORDIC step unit runs these steps in turn.
// s_tready is high only when idle.
// Reset clears the sums and the FSM; a stalled result holds in the output
// register and blocks the next final result only.
module circular_mean_angle_estimator #(
    parameter int MAX_SAMPLES = 1024,
    parameter int ANGLE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_angle
    input  logic [0:0]  s_tuser,   // [0] sample_ok
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] mean_angle
    output logic [0:0]  m_tuser    // [0] found
);

    localparam longint LIM_RAW = longint'(MAX_SAMPLES) * 64'sd32767;
    localparam longint LIM_SEL = (LIM_RAW > cmae_pkg::SUM_CAP) ? cmae_pkg::SUM_CAP : LIM_RAW;
    localparam logic signed [cmae_pkg::SUM_W:0] SUM_LIM = (cmae_pkg::SUM_W + 1)'(LIM_SEL);
    localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam logic [31:0] ROUND_ADD  = 32'd1 << (31 - ANGLE_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_RND,
        ST_ACC,
        ST_CHK,
        ST_VEC,
        ST_OUT
    } state_t;

    state_t                          state_reg, state_next;
    logic [cmae_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                            last_reg, last_next;
    logic                            found_reg, found_next;
    cmae_pkg::sum_t                  sine_sum_reg, sine_sum_next;
    cmae_pkg::sum_t                  cosine_sum_reg, cosine_sum_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [15:0]                     m_tdata_reg, m_tdata_next;
    logic                            m_tuser_reg, m_tuser_next;

    cmae_pkg::xy_t                   x_reg, x_next;
    cmae_pkg::xy_t                   y_reg, y_next;
    cmae_pkg::z_t                    z_reg, z_next;
    logic [1:0]                      quad_reg, quad_next;
    cmae_pkg::q15_t                  sin_q_reg, sin_q_next;
    cmae_pkg::q15_t                  cos_q_reg, cos_q_next;

    logic [31:0]                     phase;
    cmae_pkg::xy_t                   dx;
    cmae_pkg::xy_t                   dy;
    cmae_pkg::z_t                    atan_z;
    logic                            rot_pos;
    cmae_pkg::q15_t                  ys;
    cmae_pkg::q15_t                  xs;
    cmae_pkg::xy_t                   sin_ext;
    cmae_pkg::xy_t                   cos_ext;
    logic [31:0]                     rnd_phase;

    function automatic cmae_pkg::q15_t round_q15(input cmae_pkg::xy_t v);
        cmae_pkg::xy_t mag;
        cmae_pkg::xy_t t;
        cmae_pkg::xy_t r;
        mag = v[cmae_pkg::XY_W-1] ? -v : v;
        t   = (mag + cmae_pkg::xy_t'(16384)) >>> 15;
        r   = v[cmae_pkg::XY_W-1] ? -t : t;
        if (r > cmae_pkg::xy_t'(cmae_pkg::Q15_MAX))
            return cmae_pkg::Q15_MAX;
        else if (r < cmae_pkg::xy_t'(cmae_pkg::Q15_MIN))
            return cmae_pkg::Q15_MIN;
        else
            return cmae_pkg::q15_t'(r);
    endfunction

    function automatic cmae_pkg::q15_t neg_q15(input cmae_pkg::q15_t q);
        return (q == cmae_pkg::Q15_MIN) ? cmae_pkg::Q15_MAX : -q;
    endfunction

    function automatic cmae_pkg::sum_t sat_add(input cmae_pkg::sum_t acc,
                                               input cmae_pkg::q15_t v);
        logic signed [cmae_pkg::SUM_W:0] r;
        r = (cmae_pkg::SUM_W + 1)'(acc) + (cmae_pkg::SUM_W + 1)'(v);
        if (r > SUM_LIM)
            r = SUM_LIM;
        else if (r < -SUM_LIM)
            r = -SUM_LIM;
        return cmae_pkg::sum_t'(r);
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign phase   = (32'(s_tdata) & ANGLE_MASK) << (32 - ANGLE_BITS);
    assign dx      = y_reg >>> step_reg;
    assign dy      = x_reg >>> step_reg;
    assign atan_z  = cmae_pkg::z_t'({4'b0000, cmae_pkg::ATAN_TAB[step_reg]});
    // rotation drives z toward zero; vectoring drives y toward zero
    assign rot_pos = (state_reg == ST_VEC) ? (y_reg[cmae_pkg::XY_W-1] || (y_reg == '0))
                                           : !z_reg[cmae_pkg::Z_W-1];
    assign ys      = round_q15(y_reg);
    assign xs      = round_q15(x_reg);
    assign sin_ext = cmae_pkg::xy_t'(sine_sum_reg) <<< 16;
    assign cos_ext = cmae_pkg::xy_t'(cosine_sum_reg) <<< 16;
    assign rnd_phase = z_reg[31:0] + ROUND_ADD;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        last_next       = last_reg;
        found_next      = found_reg;
        sine_sum_next   = sine_sum_reg;
        cosine_sum_next = cosine_sum_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        quad_next       = quad_reg;
        sin_q_next      = sin_q_reg;
        cos_q_next      = cos_q_reg;

        if (m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    last_next = s_tlast;
                    if (s_tuser[0])
                    begin
                        x_next     = cmae_pkg::X_INIT;
                        y_next     = '0;
                        z_next     = cmae_pkg::z_t'({4'b0000, phase[29:0]});
                        quad_next  = phase[31:30];
                        step_next  = '0;
                        state_next = ST_ROT;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_CHK;
                    end
                end
            end
            ST_ROT, ST_VEC:
            begin
                if (rot_pos)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_z;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_z;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == cmae_pkg::STEP_W'(cmae_pkg::CORDIC_STEPS - 1))
                    state_next = (state_reg == ST_ROT) ? ST_RND : ST_OUT;
            end
            ST_RND:
            begin
                // unfold the quadrant
                case (quad_reg)
                    2'd0:
                    begin
                        sin_q_next = ys;
                        cos_q_next = xs;
                    end
                    2'd1:
                    begin
                        sin_q_next = xs;
                        cos_q_next = neg_q15(ys);
                    end
                    2'd2:
                    begin
                        sin_q_next = neg_q15(ys);
                        cos_q_next = neg_q15(xs);
                    end
                    default:
                    begin
                        sin_q_next = neg_q15(xs);
                        cos_q_next = ys;
                    end
                endcase
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                sine_sum_next   = sat_add(sine_sum_reg, sin_q_reg);
                cosine_sum_next = sat_add(cosine_sum_reg, cos_q_reg);
                state_next      = last_reg ? ST_CHK : ST_IDLE;
            end
            ST_CHK:
            begin
                if ((sine_sum_reg == '0) && (cosine_sum_reg == '0))
                begin
                    found_next = 1'b0;
                    state_next = ST_OUT;
                end
                else
                begin
                    found_next = 1'b1;
                    // fold the left half plane onto the right
                    if (cosine_sum_reg[cmae_pkg::SUM_W-1])
                    begin
                        x_next = -cos_ext;
                        y_next = -sin_ext;
                        z_next = cmae_pkg::HALF_TURN;
                    end
                    else
                    begin
                        x_next = cos_ext;
                        y_next = sin_ext;
                        z_next = '0;
                    end
                    step_next  = '0;
                    state_next = ST_VEC;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = found_reg ? 16'(rnd_phase >> (32 - ANGLE_BITS)) : 16'd0;
                    m_tuser_next    = found_reg;
                    sine_sum_next   = '0;
                    cosine_sum_next = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            last_reg       <= 1'b0;
            found_reg      <= 1'b0;
            sine_sum_reg   <= '0;
            cosine_sum_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            last_reg       <= last_next;
            found_reg      <= found_next;
            sine_sum_reg   <= sine_sum_next;
            cosine_sum_reg <= cosine_sum_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        quad_reg  <= quad_next;
        sin_q_reg <= sin_q_next;
        cos_q_reg <= cos_q_next;
    end

endmodule

### verif/cmae_mean_checker.sv
// Checker for the circular mean angle estimator: watches both stream channels,
// predicts each mean from the accepted samples and compares field by field.
// Depends on nothing but the port widths of circular_mean_angle_estimator.
module cmae_mean_checker #(
    parameter int MAX_SAMPLES = 1024,
    parameter int ANGLE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_angle
    input  logic [0:0]  s_tuser,   // [0] sample_ok
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] mean_angle
    input  logic [0:0]  m_tuser,   // [0] found
    output int          mismatches,
    output int          awaiting
);

    localparam int     TURN_STEPS  = 16;
    localparam int     REPORT_MAX  = 10;
    localparam longint START_GAIN  = 64'sd652032874;
    localparam longint SUM_LIMIT   = 64'sd67108863;
    localparam longint Q15_TOP     = 64'sd32767;
    localparam longint Q15_BOTTOM  = -64'sd32768;
    localparam longint HALF_TURN32 = 64'sd2147483648;

    // atan(2^-i) in units of 2^-32 turn
    localparam longint ARC_STEP [TURN_STEPS] = '{
        64'sd536870912, 64'sd316933405, 64'sd167458907, 64'sd85004756,
        64'sd42667332,  64'sd21354465,  64'sd10679838,  64'sd5340245,
        64'sd2670163,   64'sd1335081,   64'sd667544,    64'sd333772,
        64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861
    };

    typedef struct packed {
        logic [15:0] mean_angle;
        logic        found;
    } mean_result_t;

    mean_result_t pending_means[$];
    longint       sine_total;
    longint       cosine_total;
    int           fail_count;

    function automatic longint to_q15(longint v);
        longint r;
        // round half away from zero, drop 15 fraction bits
        if (v >= 0)
            r = (v + 64'sd16384) >>> 15;
        else
            r = -((-v + 64'sd16384) >>> 15);
        if (r > Q15_TOP)
            r = Q15_TOP;
        if (r < Q15_BOTTOM)
            r = Q15_BOTTOM;
        return r;
    endfunction

    function automatic longint neg_q15(longint v);
        return (-v > Q15_TOP) ? Q15_TOP : -v;
    endfunction

    task automatic rotate_to_q15(input logic [31:0] phase, output longint sin_q,
                                 output longint cos_q);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint ys;
        longint xs;
        x = START_GAIN;
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < TURN_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARC_STEP[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARC_STEP[i];
            end
        end
        ys = to_q15(y);
        xs = to_q15(x);
        case (phase[31:30])
            2'd0:
            begin
                sin_q = ys;
                cos_q = xs;
            end
            2'd1:
            begin
                sin_q = xs;
                cos_q = neg_q15(ys);
            end
            2'd2:
            begin
                sin_q = neg_q15(ys);
                cos_q = neg_q15(xs);
            end
            default:
            begin
                sin_q = neg_q15(xs);
                cos_q = ys;
            end
        endcase
    endtask

    function automatic logic [31:0] vector_phase(longint sin_sum, longint cos_sum);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = cos_sum * 65536;
        y = sin_sum * 65536;
        z = 0;
        // fold the left half plane onto the right one
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN32;
        end
        for (int i = 0; i < TURN_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARC_STEP[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARC_STEP[i];
            end
        end
        return z[31:0];
    endfunction

    function automatic longint add_clamped(longint acc, longint v);
        longint lim;
        longint r;
        lim = longint'(MAX_SAMPLES) * 32767;
        if (lim > SUM_LIMIT)
            lim = SUM_LIMIT;
        if (lim < 0)
            lim = 0;
        r = acc + v;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin
        logic [31:0]  angle_mask;
        logic [31:0]  phase;
        logic [31:0]  rounded;
        longint       sin_q;
        longint       cos_q;
        mean_result_t want;
        mean_result_t next_mean;
        angle_mask = (32'd1 << ANGLE_BITS) - 32'd1;
        if (!rst_n)
        begin
            pending_means.delete();
            sine_total   = 0;
            cosine_total = 0;
            fail_count   = 0;
        end
        else
        begin
            // retire a result before queuing a new request: it cannot belong to it
            if (m_tvalid && m_tready)
            begin
                if (pending_means.size() == 0)
                    note_mismatch("unexpected result, mean_angle", -1, longint'(m_tdata));
                else
                begin
                    want = pending_means.pop_front();
                    if (m_tdata !== want.mean_angle)
                        note_mismatch("mean_angle", longint'(want.mean_angle),
                                      longint'(m_tdata));
                    if (m_tuser[0] !== want.found)
                        note_mismatch("found", longint'(want.found), longint'(m_tuser[0]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0])
                begin
                    phase = (32'(s_tdata) & angle_mask) << (32 - ANGLE_BITS);
                    rotate_to_q15(phase, sin_q, cos_q);
                    sine_total   = add_clamped(sine_total, sin_q);
                    cosine_total = add_clamped(cosine_total, cos_q);
                end
                if (s_tlast)
                begin
                    if (sine_total == 0 && cosine_total == 0)
                        next_mean = '{mean_angle: 16'd0, found: 1'b0};
                    else
                    begin
                        rounded = vector_phase(sine_total, cosine_total)
                                  + (32'd1 << (31 - ANGLE_BITS));
                        rounded = (rounded >> (32 - ANGLE_BITS)) & angle_mask;
                        next_mean = '{mean_angle: rounded[15:0], found: 1'b1};
                    end
                    pending_means.push_back(next_mean);
                    sine_total   = 0;
                    cosine_total = 0;
                end
            end
        end
        mismatches <= fail_count;
        awaiting   <= pending_means.size();
    end

endmodule

### verif/tb_circular_mean_angle_estimator.sv
// Testbench top for circular_mean_angle_estimator: drives sample runs with
// random gaps and output stalls, and gives the verdict from cmae_mean_checker.
// Depends on the block's RTL (and cmae_pkg) and on verif/cmae_mean_checker.sv.
module tb_circular_mean_angle_estimator;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 640;
    localparam int CLAMP_RUN     = 1040;
    localparam int IDLE_PCT      = 13;
    localparam int GOOD_READ_PCT = 85;
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT     = 1500000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'd0;   // [15:0] sample_angle
    logic [0:0]  s_tuser  = 1'b0;    // [0] sample_ok
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [15:0] mean_angle
    logic [0:0]  m_tuser;            // [0] found
    logic        steady   = 1'b0;
    int          mismatches;
    int          awaiting;
    int          sent_count = 0;

    circular_mean_angle_estimator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cmae_mean_checker mean_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always #CLK_HALF clk = ~clk;

    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    task automatic send_sample(input logic [15:0] angle, input logic ok, input logic last);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        s_tuser  <= ok;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
    endtask

    initial
    begin
        int          base;
        int          pick;
        int          len;
        int          guard;
        logic [15:0] center;
        logic [15:0] spread;
        logic [15:0] angle;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // extremes, quadrant edges, bad reads, cancelling vectors
        send_sample(16'h0000, 1'b1, 1'b1);
        send_sample(16'hFFFF, 1'b1, 1'b1);
        send_sample(16'h4000, 1'b1, 1'b1);
        send_sample(16'h8000, 1'b1, 1'b1);
        send_sample(16'hC000, 1'b1, 1'b1);
        send_sample(16'h2000, 1'b0, 1'b1);
        send_sample(16'd100,  1'b1, 1'b0);
        send_sample(16'd200,  1'b0, 1'b0);
        send_sample(16'd300,  1'b1, 1'b1);
        send_sample(16'h1234, 1'b1, 1'b0);
        send_sample(16'h9234, 1'b1, 1'b1);
        send_sample(16'd40000, 1'b1, 1'b0);
        send_sample(16'd41000, 1'b0, 1'b1);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'h0000, 1'b1, 1'b0);
        send_sample(16'h8000, 1'b1, 1'b0);
        send_sample(16'h4000, 1'b1, 1'b1);
        send_sample(16'hAAAA, 1'b1, 1'b0);
        send_sample(16'h5555, 1'b1, 1'b1);

        // drive the cosine sum into its negative clamp, then pull the sine up
        for (int i = 0; i < CLAMP_RUN; i++)
            send_sample(16'h8000 + 16'($urandom_range(64)) - 16'd32, 1'b1, 1'b0);
        for (int i = 0; i < 6; i++)
            send_sample(16'h4000, 1'b1, i == 5);

        base = sent_count;
        while (sent_count - base < RANDOM_ITEMS)
        begin
            steady = (sent_count - base >= 200) && (sent_count - base < 450);
            pick   = $urandom_range(99);
            if (pick < 8)
                send_sample(16'($urandom), 1'($urandom), 1'($urandom));
            else if (pick < 12)
            begin
                // run with no good read at all
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_sample(16'($urandom), 1'b0, i == len - 1);
            end
            else if (pick < 17)
            begin
                // opposite pairs cancel to a zero vector
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    angle = 16'($urandom);
                    send_sample(angle, 1'b1, 1'b0);
                    send_sample(angle ^ 16'h8000, 1'b1, i == len - 1);
                end
            end
            else
            begin
                len    = $urandom_range(1, 12);
                center = 16'($urandom);
                case ($urandom_range(2))
                    0:       spread = 16'h00FF;
                    1:       spread = 16'h0FFF;
                    default: spread = 16'hFFFF;
                endcase
                for (int i = 0; i < len; i++)
                    send_sample(center + (16'($urandom) & spread) - (spread >> 1),
                                $urandom_range(99) < GOOD_READ_PCT, i == len - 1);
            end
        end
        steady = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        guard = 0;
        while (awaiting != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("circular_mean_angle_estimator verification clean");
        else
            $display("circular_mean_angle_estimator verification failed");
        $finish;
    end

    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("circular_mean_angle_estimator verification failed");
        $finish;
    end

endmodule

### files.f
rtl/cmae_pkg.sv
rtl/circular_mean_angle_estimator.sv
verif/cmae_mean_checker.sv
verif/tb_circular_mean_angle_estimator.sv
